@@ rtl/core/rog_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rog_pkg
// shared types and constants for the reference-counted output power gate
// ----------------------------------------------------------------------------
package rog_pkg;

    localparam int SOURCES        = 4;
    localparam int MAX_PER_SOURCE = 255;

    localparam int FUNC_W    = 3;
    localparam int SRC_ID_W  = 2;
    localparam int EXT_W     = 8;
    localparam int SRC_CNT_W = 8;
    localparam int TOTAL_W   = 10;
    localparam int DELAY_W   = 16;
    localparam int FAULT_W   = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 16;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_PLAYING = 2'd1,
        MODE_DELAY   = 2'd2
    } gate_mode_t;

    localparam logic [FUNC_W-1:0] FUNC_ACQUIRE    = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE    = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_OPEN_REQ   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLOSE_REQ  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_TICK       = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_LOCK_CHECK = 3'd5;

    localparam logic [FAULT_W-1:0] FAULT_NONE      = 2'd0;
    localparam logic [FAULT_W-1:0] FAULT_REL_ZERO  = 2'd1;
    localparam logic [FAULT_W-1:0] FAULT_ACQ_SAT   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_GATE_ENABLED    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_DELAY_TICKS = 1'd1;

    localparam logic [DELAY_W-1:0] OFF_DELAY_RESET = 16'd3000;

endpackage : rog_pkg
`default_nettype wire

@@ rtl/core/refcounted_output_power_gate.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// refcounted_output_power_gate
// per-source reference counting with a gated open/close and tick-driven
// delayed close
// ----------------------------------------------------------------------------
// an accepted transaction passes the input register, then the result register
// throughput: one transaction per cycle unless out_stall holds the result; the
// state update and result are one combinational pass, input to result register
// reset: mode idle, all counts and countdown zero, gating enabled, delay 3000
// ----------------------------------------------------------------------------
module refcounted_output_power_gate
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,

    input  wire logic                             cfg_we,
    input  wire logic [rog_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [rog_pkg::CFG_W-1:0]        cfg_data,

    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [rog_pkg::FUNC_W-1:0]       func,
    input  wire logic [rog_pkg::SRC_ID_W-1:0]     source_id,
    input  wire logic                             refresh_flag,
    input  wire logic [rog_pkg::EXT_W-1:0]        external_locks,

    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic                                  permit,
    output logic                                  open_cmd,
    output logic                                  close_cmd,
    output logic [1:0]                            gate_state,
    output logic [rog_pkg::TOTAL_W-1:0]           total_count,
    output logic [rog_pkg::SRC_CNT_W-1:0]         source_count,
    output logic [rog_pkg::FAULT_W-1:0]           fault
);
    import rog_pkg::*;

    // configuration
    logic                   gate_enabled_reg;
    logic [DELAY_W-1:0]     off_delay_reg;

    // input register
    logic                   in_valid_reg;
    logic [FUNC_W-1:0]      func_reg;
    logic [SRC_ID_W-1:0]    src_reg;
    logic                   refresh_reg;
    logic [EXT_W-1:0]       ext_reg;

    // gate state
    gate_mode_t             mode_reg, mode_next;
    logic [TOTAL_W-1:0]     total_reg, total_next;
    logic [SRC_CNT_W-1:0]   per_src_reg [SOURCES];
    logic [SRC_CNT_W-1:0]   per_src_next [SOURCES];
    logic [DELAY_W-1:0]     delay_reg, delay_next;
    logic                   force_open_reg, force_open_next;
    logic                   force_close_reg, force_close_next;

    // result register
    logic                   out_valid_reg;
    logic                   permit_reg, permit_next;
    logic                   open_cmd_reg, open_cmd_next;
    logic                   close_cmd_reg, close_cmd_next;
    logic [1:0]             gate_state_reg;
    logic [TOTAL_W-1:0]     total_count_reg;
    logic [SRC_CNT_W-1:0]   source_count_reg, source_count_next;
    logic [FAULT_W-1:0]     fault_reg, fault_next;

    logic                   fire;
    logic                   in_accept;
    logic                   src_ok;
    logic [SRC_CNT_W-1:0]   cur_src;
    logic                   held;
    logic [DELAY_W-1:0]     delay_dec;

    assign fire      = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !fire;
    assign in_accept = in_valid && !in_stall;

    assign src_ok    = 32'(src_reg) < SOURCES;
    assign cur_src   = src_ok ? per_src_reg[src_reg] : '0;
    assign held      = (total_reg != '0) || (ext_reg != '0);
    assign delay_dec = delay_reg - DELAY_W'(1);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_enabled_reg <= 1'b1;
            off_delay_reg    <= OFF_DELAY_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GATE_ENABLED:    gate_enabled_reg <= cfg_data[0];
                CFG_OFF_DELAY_TICKS: off_delay_reg    <= cfg_data[DELAY_W-1:0];
                default:             ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            func_reg    <= func;
            src_reg     <= source_id;
            refresh_reg <= refresh_flag;
            ext_reg     <= external_locks;
        end
    end

    // next state and result
    always_comb
    begin
        mode_next         = mode_reg;
        total_next        = total_reg;
        per_src_next      = per_src_reg;
        delay_next        = delay_reg;
        force_open_next   = force_open_reg;
        force_close_next  = force_close_reg;
        permit_next       = 1'b0;
        open_cmd_next     = 1'b0;
        close_cmd_next    = 1'b0;
        fault_next        = FAULT_NONE;
        source_count_next = '0;

        case (func_reg)
            FUNC_ACQUIRE:
            begin
                if (gate_enabled_reg && src_ok)
                begin
                    if (32'(cur_src) >= MAX_PER_SOURCE)
                    begin
                        fault_next = FAULT_ACQ_SAT;
                    end
                    else
                    begin
                        per_src_next[src_reg] = cur_src + SRC_CNT_W'(1);
                        total_next            = total_reg + TOTAL_W'(1);
                        if (total_reg == '0 && mode_reg == MODE_IDLE)
                        begin
                            open_cmd_next = 1'b1;
                        end
                    end
                end
            end
            FUNC_RELEASE:
            begin
                if (gate_enabled_reg && src_ok)
                begin
                    if (cur_src == '0)
                    begin
                        fault_next = FAULT_REL_ZERO;
                    end
                    else
                    begin
                        per_src_next[src_reg] = cur_src - SRC_CNT_W'(1);
                        if (total_reg != '0)
                        begin
                            total_next = total_reg - TOTAL_W'(1);
                        end
                    end
                end
            end
            FUNC_OPEN_REQ:
            begin
                if (!gate_enabled_reg)
                begin
                    permit_next = 1'b1;
                end
                else if (force_open_reg)
                begin
                    force_open_next = 1'b0;
                    permit_next     = 1'b1;
                end
                else if (mode_reg == MODE_IDLE)
                begin
                    permit_next = 1'b1;
                end
                else if (mode_reg == MODE_DELAY)
                begin
                    mode_next  = MODE_PLAYING;
                    delay_next = '0;
                end
                if (permit_next && mode_reg != MODE_PLAYING)
                begin
                    mode_next  = MODE_PLAYING;
                    delay_next = '0;
                end
            end
            FUNC_CLOSE_REQ:
            begin
                if (!gate_enabled_reg)
                begin
                    permit_next = 1'b1;
                end
                else if (force_close_reg)
                begin
                    force_close_next = 1'b0;
                    permit_next      = 1'b1;
                end
                else if (mode_reg == MODE_PLAYING && !held)
                begin
                    mode_next  = MODE_DELAY;
                    delay_next = off_delay_reg;
                end
                if (permit_next)
                begin
                    mode_next  = MODE_IDLE;
                    delay_next = '0;
                end
            end
            FUNC_TICK:
            begin
                if (mode_reg == MODE_DELAY && !force_close_reg)
                begin
                    if (delay_reg != '0)
                    begin
                        delay_next = delay_dec;
                    end
                    // expiry on an empty count or on the last decrement
                    if (delay_reg == '0 || delay_dec == '0)
                    begin
                        if (held)
                        begin
                            mode_next  = MODE_PLAYING;
                            delay_next = '0;
                        end
                        else
                        begin
                            force_close_next = 1'b1;
                            close_cmd_next   = 1'b1;
                        end
                    end
                end
            end
            FUNC_LOCK_CHECK:
            begin
                if (held)
                begin
                    if (mode_reg == MODE_IDLE)
                    begin
                        open_cmd_next = 1'b1;
                    end
                    else
                    begin
                        if (mode_reg == MODE_DELAY)
                        begin
                            mode_next  = MODE_PLAYING;
                            delay_next = '0;
                        end
                        // only external locks hold the device and refresh is set: force a reopen
                        if (refresh_reg && ext_reg != '0 && total_reg == '0)
                        begin
                            force_open_next = 1'b1;
                            open_cmd_next   = 1'b1;
                        end
                    end
                end
                else if (mode_reg == MODE_PLAYING)
                begin
                    mode_next  = MODE_DELAY;
                    delay_next = off_delay_reg;
                end
            end
            default:
            begin
            end
        endcase

        if (src_ok)
        begin
            source_count_next = per_src_next[src_reg];
        end
    end

    // gate state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_IDLE;
            total_reg       <= '0;
            delay_reg       <= '0;
            force_open_reg  <= 1'b0;
            force_close_reg <= 1'b0;
            for (int i = 0; i < SOURCES; i++)
            begin
                per_src_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            mode_reg        <= mode_next;
            total_reg       <= total_next;
            delay_reg       <= delay_next;
            force_open_reg  <= force_open_next;
            force_close_reg <= force_close_next;
            per_src_reg     <= per_src_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            permit_reg       <= permit_next;
            open_cmd_reg     <= open_cmd_next;
            close_cmd_reg    <= close_cmd_next;
            gate_state_reg   <= mode_next;
            total_count_reg  <= total_next;
            source_count_reg <= source_count_next;
            fault_reg        <= fault_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign permit       = permit_reg;
    assign open_cmd     = open_cmd_reg;
    assign close_cmd    = close_cmd_reg;
    assign gate_state   = gate_state_reg;
    assign total_count  = total_count_reg;
    assign source_count = source_count_reg;
    assign fault        = fault_reg;

endmodule : refcounted_output_power_gate
`default_nettype wire
